// ===== rtl/bscm_pkg.sv =====
// ----------------------------------------------------------------------------
// bscm_pkg
// Shared types, codes and the byte-wise CRC-16 (poly 0x1021) for the
// byte stream CRC / chunk / zero-run mapper.
// ----------------------------------------------------------------------------
package bscm_pkg;

  // result kinds carried on m_tuser
  typedef enum logic [1:0] {
    KIND_RANGE   = 2'd0,
    KIND_CHUNK   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  // input word kinds carried on s_tuser
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // configuration register indexes
  localparam logic REG_MIN_NULL  = 1'b0;
  localparam logic REG_CHUNK_LEN = 1'b1;

  localparam logic [31:0] MIN_NULL_RESET  = 32'd40;
  localparam logic [31:0] CHUNK_LEN_RESET = 32'd4096;
  localparam logic [31:0] CNT_MAX         = 32'hFFFF_FFFF;

  // results per input word, and depth of the result queue
  localparam int unsigned MAX_RES  = 3;
  localparam int unsigned RQ_DEPTH = 4;

  typedef struct packed {
    logic        last;
    logic [31:0] range_count;
    logic [31:0] chunk_number;
    logic [15:0] crc_value;
    logic [31:0] end_offset;
    logic [31:0] start_offset;
    kind_t       kind;
  } res_t;

  // one byte of CRC-16/XMODEM, table-free byte-wise form
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = {c_in[7:0], c_in[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

  // counter increment that sticks at all ones
  function automatic logic [31:0] inc_sat(input logic [31:0] x);
    return (x == CNT_MAX) ? x : x + 32'd1;
  endfunction

endpackage

// ===== rtl/bscm_core.sv =====
// ----------------------------------------------------------------------------
// bscm_core
// Stream state, config registers and the combinational per-word update.
// Produces up to three results for the accepted word, in order.
// ----------------------------------------------------------------------------
module bscm_core #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 mode,
  input  logic [7:0]           data_byte,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data,
  output bscm_pkg::res_t       res [bscm_pkg::MAX_RES],
  output logic [1:0]           res_n
);
  import bscm_pkg::*;

  localparam int unsigned OB = OFFSET_BITS;
  localparam int unsigned W  = ((OB > 32) ? OB : 32) + 1;
  localparam logic [63:0]   LIM64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - OB);
  localparam logic [OB-1:0] LIM   = LIM64[OB-1:0];
  localparam logic [W-1:0]  LIMW  = W'(LIM64);

  // offset + count, saturating at the offset limit
  function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a,
                                            input logic [31:0]   b);
    logic [W-1:0] s;
    s = W'(a) + W'(b);
    return (s > LIMW) ? LIM : s[OB-1:0];
  endfunction

  // config registers
  logic [31:0] min_null_length, chunk_len, chunk_len_next;

  // stream state
  logic [15:0]   stream_crc, blk_crc;
  logic [31:0]   bytes_in_chunk, chunk_index, run_length, ranges_reported;
  logic [OB-1:0] byte_position, zrun_origin;
  logic [OB-1:0] chunk_start;   // chunk_index * chunk_len, saturated

  logic [15:0]   stream_crc_next, blk_crc_next;
  logic [31:0]   bytes_in_chunk_next, chunk_index_next, run_length_next;
  logic [31:0]   ranges_reported_next;
  logic [OB-1:0] byte_position_next, zrun_origin_next, chunk_start_next;

  // per-word intermediates
  logic [15:0] ccrc1;
  logic [31:0] bic1, lim, rr_close;
  logic        run_rep, chunk_emit, end_chunk;
  logic [63:0] prod;
  res_t        r_chunk, r_range, r_sum, cand_a, cand_b, cand_c;
  logic        va, vb, vc;

  // config write mux feeds the chunk start product
  always_comb begin
    chunk_len_next = chunk_len;
    if (cfg_we && cfg_index == REG_CHUNK_LEN) chunk_len_next = cfg_data;
  end

  always_comb begin
    ccrc1    = crc_byte(blk_crc, data_byte);
    bic1     = inc_sat(bytes_in_chunk);
    lim      = (min_null_length == 32'd0) ? 32'd1 : min_null_length;
    run_rep  = (run_length != 32'd0) && (run_length >= lim);
    rr_close = run_rep ? inc_sat(ranges_reported) : ranges_reported;
    chunk_emit = (chunk_len != 32'd0) && (bic1 >= chunk_len);
    end_chunk  = (bytes_in_chunk != 32'd0);

    // zero range result (closing the current run)
    r_range.kind         = KIND_RANGE;
    r_range.start_offset = 32'(zrun_origin);
    r_range.end_offset   = 32'(sat_add(zrun_origin, run_length));
    r_range.crc_value    = 16'h0000;
    r_range.chunk_number = 32'd0;
    r_range.range_count  = rr_close;
    r_range.last         = 1'b0;

    // chunk result; on a byte the run is not closed yet
    r_chunk.kind         = KIND_CHUNK;
    r_chunk.start_offset = 32'(chunk_start);
    r_chunk.chunk_number = chunk_index;
    r_chunk.last         = 1'b0;
    if (mode == MODE_DATA) begin
      r_chunk.end_offset  = 32'(sat_add(chunk_start, bic1));
      r_chunk.crc_value   = ccrc1;
      r_chunk.range_count = ranges_reported;
    end else begin
      r_chunk.end_offset  = 32'(sat_add(chunk_start, bytes_in_chunk));
      r_chunk.crc_value   = blk_crc;
      r_chunk.range_count = rr_close;
    end

    // end summary
    r_sum.kind         = KIND_SUMMARY;
    r_sum.start_offset = 32'd0;
    r_sum.end_offset   = 32'(byte_position);
    r_sum.crc_value    = stream_crc;
    r_sum.chunk_number = end_chunk ? inc_sat(chunk_index) : chunk_index;
    r_sum.range_count  = rr_close;
    r_sum.last         = 1'b0;

    // defaults: hold
    stream_crc_next      = stream_crc;
    blk_crc_next         = blk_crc;
    bytes_in_chunk_next  = bytes_in_chunk;
    chunk_index_next     = chunk_index;
    byte_position_next   = byte_position;
    zrun_origin_next     = zrun_origin;
    run_length_next      = run_length;
    ranges_reported_next = ranges_reported;

    if (mode == MODE_DATA) begin
      // byte: chunk first, then range
      cand_a = r_chunk;  va = chunk_emit;
      cand_b = r_range;  vb = (data_byte != 8'h00) && run_rep;
      cand_c = r_sum;    vc = 1'b0;
    end else begin
      // end marker: range, partial chunk, summary
      cand_a = r_range;  va = run_rep;
      cand_b = r_chunk;  vb = end_chunk;
      cand_c = r_sum;    vc = 1'b1;
    end

    if (accept) begin
      if (mode == MODE_DATA) begin
        stream_crc_next = crc_byte(stream_crc, data_byte);
        if (chunk_emit) begin
          blk_crc_next        = 16'h0000;
          bytes_in_chunk_next = 32'd0;
          chunk_index_next    = inc_sat(chunk_index);
        end else begin
          blk_crc_next        = ccrc1;
          bytes_in_chunk_next = bic1;
        end
        if (data_byte == 8'h00) begin
          if (run_length == 32'd0) zrun_origin_next = byte_position;
          run_length_next = inc_sat(run_length);
        end else begin
          ranges_reported_next = rr_close;
          run_length_next      = 32'd0;
        end
        byte_position_next = sat_add(byte_position, 32'd1);
      end else begin
        stream_crc_next      = 16'h0000;
        blk_crc_next         = 16'h0000;
        bytes_in_chunk_next  = 32'd0;
        chunk_index_next     = 32'd0;
        byte_position_next   = '0;
        zrun_origin_next     = '0;
        run_length_next      = 32'd0;
        ranges_reported_next = 32'd0;
      end
    end

    // chunk start for the next word, kept in step with index and size
    prod = 64'(chunk_index_next) * 64'(chunk_len_next);
    chunk_start_next = (prod > LIM64) ? LIM : prod[OB-1:0];
  end

  // compact the candidates in order and mark the last one
  always_comb begin
    res[0] = va ? cand_a : (vb ? cand_b : cand_c);
    res[1] = (va && vb) ? cand_b : cand_c;
    res[2] = cand_c;
    res_n  = 2'(va) + 2'(vb) + 2'(vc);
    unique case (res_n)
      2'd1:    res[0].last = 1'b1;
      2'd2:    res[1].last = 1'b1;
      2'd3:    res[2].last = 1'b1;
      default: ;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_null_length <= MIN_NULL_RESET;
      chunk_len       <= CHUNK_LEN_RESET;
    end else begin
      chunk_len <= chunk_len_next;
      if (cfg_we && cfg_index == REG_MIN_NULL) min_null_length <= cfg_data;
    end
  end

  // stream state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_crc      <= 16'h0000;
      blk_crc         <= 16'h0000;
      bytes_in_chunk  <= 32'd0;
      chunk_index     <= 32'd0;
      byte_position   <= '0;
      zrun_origin     <= '0;
      run_length      <= 32'd0;
      ranges_reported <= 32'd0;
      chunk_start     <= '0;
    end else begin
      stream_crc      <= stream_crc_next;
      blk_crc         <= blk_crc_next;
      bytes_in_chunk  <= bytes_in_chunk_next;
      chunk_index     <= chunk_index_next;
      byte_position   <= byte_position_next;
      zrun_origin     <= zrun_origin_next;
      run_length      <= run_length_next;
      ranges_reported <= ranges_reported_next;
      chunk_start     <= chunk_start_next;
    end
  end

endmodule

// ===== rtl/bscm_rq.sv =====
// ----------------------------------------------------------------------------
// bscm_rq
// Result queue: takes up to three results in one cycle, hands out one per
// cycle while pop is high. Doubles as the output register of the block.
// ----------------------------------------------------------------------------
module bscm_rq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [1:0]      push_n,
  input  bscm_pkg::res_t  push_data [bscm_pkg::MAX_RES],
  input  logic            pop,
  output bscm_pkg::res_t  head,
  output logic [2:0]      count
);
  import bscm_pkg::*;

  res_t       slot [RQ_DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] n_in;

  assign n_in = push ? {1'b0, push_n} : 3'd0;
  assign head = slot[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + n_in[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + n_in - {2'b00, pop};
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (3'(i) < n_in) slot[wr_ptr + 2'(i)] <= push_data[i];
    end
  end

endmodule

// ===== rtl/byte_stream_crc_chunk_null_run_mapper.sv =====
// ----------------------------------------------------------------------------
// byte_stream_crc_chunk_null_run_mapper
// Whole-stream and per-chunk CRC-16/XMODEM with zero-run range reporting.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one file byte per word (s_tuser = 0) or the end marker
//   (s_tuser = 1, s_tdata ignored). m_* carries results: chunk CRC records,
//   zero-byte ranges [start, end) and one summary per end marker. m_tlast
//   marks the final result caused by an input word.
//   cfg_* writes min_null_length (index 0) and the chunk length (index 1);
//   it is always ready and is meant to be used between words with no
//   results outstanding.
//   Each result is registered in the result queue and reaches m_* once the
//   results ahead of it are taken. Throughput: one input word per cycle
//   while s_tready is high; the byte CRC, counters and chunk start product
//   are combinational. A word can make up to three results, drained one
//   per cycle while m_tready is high from a four-entry result queue; s_tready
//   is high while it holds at most one result and low while it holds more.
//   Reset clears all stream state and loads the register defaults (40, 4096).
//   When m_tready is low the queue fills and s_tready drops; nothing is lost.
//   After an end marker the stream state returns to reset; registers keep.
// ----------------------------------------------------------------------------
module byte_stream_crc_chunk_null_run_mapper #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  // input words
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] mode
  // result words
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // [31:0] start_offset, [63:32] end_offset,
                                  // [79:64] crc_value, [111:80] chunk_number,
                                  // [143:112] range_count
  output logic [1:0]   m_tuser,   // [1:0] kind
  output logic         m_tlast,   // last
  // config writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import bscm_pkg::*;

  logic       accept, pop;
  logic [1:0] res_n;
  logic [2:0] count;
  res_t       res [MAX_RES];
  res_t       head;

  assign s_tready  = (count <= 3'd1);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = (count != 3'd0);
  assign pop       = m_tvalid && m_tready;

  // per-word update
  bscm_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (s_tuser),
    .data_byte (s_tdata),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res),
    .res_n     (res_n)
  );

  // result queue / output register
  bscm_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_n    (res_n),
    .push_data (res),
    .pop       (pop),
    .head      (head),
    .count     (count)
  );

  assign m_tdata = {head.range_count, head.chunk_number, head.crc_value,
                    head.end_offset, head.start_offset};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  // queue never overfills
  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(RQ_DEPTH))
    else $error("result queue overflow");

  // an accepted end marker always leaves m_tvalid high on the next cycle
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == MODE_END) |=> m_tvalid)
    else $error("no result after end marker");

  // a summary result is always marked last
  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_SUMMARY) |-> m_tlast)
    else $error("summary not marked last");

endmodule
